// ===== rtl/core/pga_pkg.sv =====
`default_nettype none
package pga_pkg;

	localparam int NUM_AXES  = 3;
	localparam int MAX_DIMS  = 3;
	localparam int MAX_RANGE = 1024;
	localparam int IDX_W     = 30;
	localparam int CRD_W     = 10;
	localparam int RNG_W     = 11;
	localparam int COORD_W   = 16;
	localparam int CELLS     = IDX_W;
	localparam int AXIS_SPAN = CELLS + 1;
	localparam int LAST_W    = 1 + NUM_AXES * AXIS_SPAN;

	typedef enum logic [1:0] {
		REG_DIMS    = 2'd0,
		REG_RANGE_X = 2'd1,
		REG_RANGE_Y = 2'd2,
		REG_RANGE_Z = 2'd3
	} pga_reg_t;

	typedef enum logic {
		OP_WRAP  = 1'b0,
		OP_SPLIT = 1'b1
	} pga_op_t;

	typedef struct packed {
		pga_op_t                          op;
		logic [1:0]                       dims;
		logic [NUM_AXES-1:0][RNG_W-1:0]   rng;
		logic [NUM_AXES-1:0][COORD_W-1:0] mag;
		logic [NUM_AXES-1:0]              neg;
		logic [IDX_W-1:0]                 num;
		logic [IDX_W-1:0]                 quo;
		logic [CRD_W-1:0]                 rem;
		logic [NUM_AXES-1:0][CRD_W-1:0]   crd;
	} pga_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]               idx;
		logic [NUM_AXES-1:0][CRD_W-1:0] crd;
	} pga_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/pga_cell.sv =====
`default_nettype none
module pga_cell
	import pga_pkg::*;
#(
	parameter int AXIS = 0,
	parameter int BIT  = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  var  pga_word_t in_word,
	output logic           out_valid,
	output pga_word_t      out_word
);

	logic [RNG_W-1:0] trial;
	logic [RNG_W-1:0] rng;
	logic             ge;
	pga_word_t        nxt;

	always_comb begin
		rng   = in_word.rng[AXIS];
		trial = {in_word.rem, in_word.num[BIT]};
		ge    = trial >= rng;
		nxt   = in_word;
		nxt.quo[BIT] = ge;
		nxt.rem = ge ? CRD_W'(trial - rng) : CRD_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pga_axis_end.sv =====
`default_nettype none
module pga_axis_end
	import pga_pkg::*;
#(
	parameter int AXIS = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  var  pga_word_t in_word,
	output logic           out_valid,
	output pga_word_t      out_word
);

	localparam int NEXT = (AXIS + 1) % NUM_AXES;

	logic [CRD_W-1:0] c;
	pga_word_t        nxt;

	always_comb begin
		nxt = in_word;
		c   = in_word.rem;
		if (in_word.op == OP_WRAP && in_word.neg[AXIS] && in_word.rem != '0) begin
			c = CRD_W'(in_word.rng[AXIS] - RNG_W'(in_word.rem));
		end
		nxt.crd[AXIS] = (2'(AXIS) < in_word.dims) ? c : '0;
		nxt.num = (in_word.op == OP_SPLIT) ? in_word.quo
			: IDX_W'(in_word.mag[NEXT]);
		nxt.quo = '0;
		nxt.rem = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pga_linear.sv =====
`default_nettype none
module pga_linear
	import pga_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  var  pga_word_t in_word,
	output logic           out_valid,
	output pga_result_t    out_res
);

	localparam int MID_W = 2 * RNG_W;

	logic             valid_s1;
	logic [MID_W-1:0] mid_s1;
	pga_word_t        word_s1;
	logic [MID_W+RNG_W-1:0] prod;

	assign prod = word_s1.rng[0] * mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= in_word;
			mid_s1  <= MID_W'(in_word.rng[1]) * MID_W'(in_word.crd[2])
				+ MID_W'(in_word.crd[1]);
			out_res.crd <= word_s1.crd;
			out_res.idx <= (word_s1.op == OP_SPLIT) ? '0
				: IDX_W'(prod + (MID_W+RNG_W)'(word_s1.crd[0]));
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/periodic_grid_address_unit.sv =====
// throughput: one word per cycle while the output is not stalled; an input register, a row
// of 90 restoring division cells (30 per axis) with an end stage per axis, two multiply
// stages and the output register; the row keeps moving while a result waits until an item
// reaches its last stage
// reset: asynchronous, clears all valid flags, dims_used to 2 and all ranges to 1
`default_nettype none
module periodic_grid_address_unit
	import pga_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // coord_x, coord_y, coord_z, linear_index, zero fill
	input  wire logic        s_tuser,   // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata    // index_out, wrapped_x, wrapped_y, wrapped_z, zero fill
);

	logic [1:0]       dims_q;
	logic [RNG_W-1:0] range_x_q;
	logic [RNG_W-1:0] range_y_q;
	logic [RNG_W-1:0] range_z_q;
	pga_reg_t         reg_sel;

	logic [1:0]                       eff_dims;
	logic [NUM_AXES-1:0][RNG_W-1:0]   eff_rng;
	logic [NUM_AXES-1:0][COORD_W-1:0] coord;

	logic              en;
	logic              en_out;
	logic [LAST_W-1:0] v;
	pga_word_t         w [LAST_W];
	pga_word_t         entry;
	logic              lin_valid;
	pga_result_t       lin_res;
	pga_result_t       out_res_q;

	function automatic logic [RNG_W-1:0] eff_range(input logic [RNG_W-1:0] r);
		logic [RNG_W-1:0] e;
		e = r;
		if (r == '0) begin
			e = RNG_W'(1);
		end else if (r > RNG_W'(MAX_RANGE)) begin
			e = RNG_W'(MAX_RANGE);
		end
		return e;
	endfunction

	assign reg_sel = pga_reg_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q    <= 2'd2;
			range_x_q <= RNG_W'(1);
			range_y_q <= RNG_W'(1);
			range_z_q <= RNG_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_DIMS:    dims_q    <= pwdata[1:0];
				REG_RANGE_X: range_x_q <= pwdata[RNG_W-1:0];
				REG_RANGE_Y: range_y_q <= pwdata[RNG_W-1:0];
				REG_RANGE_Z: range_z_q <= pwdata[RNG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DIMS:    prdata = 32'(dims_q);
			REG_RANGE_X: prdata = 32'(range_x_q);
			REG_RANGE_Y: prdata = 32'(range_y_q);
			REG_RANGE_Z: prdata = 32'(range_z_q);
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		eff_dims = dims_q;
		if (dims_q == 2'd0) begin
			eff_dims = 2'd1;
		end else if (dims_q > 2'(MAX_DIMS)) begin
			eff_dims = 2'(MAX_DIMS);
		end
		eff_rng[0] = eff_range(range_x_q);
		eff_rng[1] = eff_range(range_y_q);
		eff_rng[2] = eff_range(range_z_q);
		coord[0] = s_tdata[15:0];
		coord[1] = s_tdata[31:16];
		coord[2] = s_tdata[47:32];
	end

	always_comb begin
		entry      = '0;
		entry.op   = pga_op_t'(s_tuser);
		entry.dims = eff_dims;
		entry.rng  = eff_rng;
		for (int k = 0; k < NUM_AXES; k++) begin
			entry.neg[k] = coord[k][COORD_W-1];
			entry.mag[k] = coord[k][COORD_W-1] ? COORD_W'(~coord[k] + 1'b1) : coord[k];
		end
		entry.num = (entry.op == OP_SPLIT) ? s_tdata[77:48] : IDX_W'(entry.mag[0]);
	end

	assign en_out   = !m_tvalid || m_tready;
	assign en       = !lin_valid || en_out;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w[0] <= entry;
		end
	end

	for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
		for (genvar j = 0; j < CELLS; j++) begin : g_cell
			pga_cell #(.AXIS(k), .BIT(CELLS - 1 - j)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (v[k*AXIS_SPAN + j]),
				.in_word   (w[k*AXIS_SPAN + j]),
				.out_valid (v[k*AXIS_SPAN + j + 1]),
				.out_word  (w[k*AXIS_SPAN + j + 1])
			);
		end
		pga_axis_end #(.AXIS(k)) u_end (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v[k*AXIS_SPAN + CELLS]),
			.in_word   (w[k*AXIS_SPAN + CELLS]),
			.out_valid (v[(k+1)*AXIS_SPAN]),
			.out_word  (w[(k+1)*AXIS_SPAN])
		);
	end

	pga_linear u_linear (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v[LAST_W-1]),
		.in_word   (w[LAST_W-1]),
		.out_valid (lin_valid),
		.out_res   (lin_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en_out) begin
			m_tvalid <= lin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_res_q <= lin_res;
		end
	end

	assign m_tdata = {4'b0, out_res_q.crd[2], out_res_q.crd[1], out_res_q.crd[0],
		out_res_q.idx};

`ifndef ASSERT_OFF
	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (RNG_W'(m_tdata[39:30]) < eff_rng[0]))
		else $error("wrapped_x beyond range");
	a_y_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && eff_dims < 2'd2) |-> (m_tdata[49:40] == '0))
		else $error("wrapped_y set for unused axis");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && lin_valid))
		else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/periodic_grid_address_unit_test.sv =====
`default_nettype none
module periodic_grid_address_unit_test;
	import pga_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CRD_W-1:0] z;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] x;
		logic [IDX_W-1:0] idx;
	} grid_addr_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	periodic_grid_address_unit dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	localparam int LATENCY = 97;
	localparam int WATCHDOG_LIMIT = 4000;

	logic [1:0]       cfg_dims;
	logic [RNG_W-1:0] cfg_rng [NUM_AXES];
	grid_addr_t       expected_addrs [$];
	int               mismatches;
	int               idle_cycles;
	bit               send_gaps;
	bit               recv_gaps;
	int               hold_off;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int eff_range(logic [RNG_W-1:0] r);
		if (r == 0) return 1;
		if (r > MAX_RANGE) return MAX_RANGE;
		return int'(r);
	endfunction

	function automatic int floor_wrap(logic [COORD_W-1:0] c, int r);
		int v;
		v = int'($signed(c)) % r;
		if (v < 0) v += r;
		return v;
	endfunction

	function automatic grid_addr_t predict_addr(pga_op_t op, logic [COORD_W-1:0] cx,
			logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz, logic [IDX_W-1:0] lin);
		grid_addr_t res;
		int d;
		int r [NUM_AXES];
		longint c [NUM_AXES];
		longint rest;
		longint idx;
		logic [COORD_W-1:0] crd [NUM_AXES];
		d = (cfg_dims == 0) ? 1 : ((cfg_dims > MAX_DIMS) ? MAX_DIMS : int'(cfg_dims));
		crd[0] = cx;
		crd[1] = cy;
		crd[2] = cz;
		for (int k = 0; k < NUM_AXES; k++) begin
			r[k] = eff_range(cfg_rng[k]);
			c[k] = 0;
		end
		idx = 0;
		if (op == OP_WRAP) begin
			for (int k = 0; k < d; k++) c[k] = floor_wrap(crd[k], r[k]);
			idx = c[d-1];
			for (int k = d - 1; k > 0; k--) idx = idx * r[k-1] + c[k-1];
		end else begin
			rest = lin;
			for (int k = 0; k < d; k++) begin
				c[k] = rest % r[k];
				rest = rest / r[k];
			end
		end
		res.idx = idx[IDX_W-1:0];
		res.x = c[0][CRD_W-1:0];
		res.y = c[1][CRD_W-1:0];
		res.z = c[2][CRD_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(pga_reg_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_DIMS:    cfg_dims <= v[1:0];
			REG_RANGE_X: cfg_rng[0] <= v[RNG_W-1:0];
			REG_RANGE_Y: cfg_rng[1] <= v[RNG_W-1:0];
			default:     cfg_rng[2] <= v[RNG_W-1:0];
		endcase
		@(negedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_addrs.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic set_grid(logic [1:0] d, logic [RNG_W-1:0] rx, logic [RNG_W-1:0] ry,
			logic [RNG_W-1:0] rz);
		drain();
		write_reg(REG_DIMS, 32'(d));
		write_reg(REG_RANGE_X, 32'(rx));
		write_reg(REG_RANGE_Y, 32'(ry));
		write_reg(REG_RANGE_Z, 32'(rz));
	endtask

	task automatic send_word(pga_op_t op, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
			logic [COORD_W-1:0] cz, logic [IDX_W-1:0] lin);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, lin, cz, cy, cx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_addrs.push_back(predict_addr(op, cx, cy, cz, lin));
		@(negedge clk);
	endtask

	task automatic send_random(int pct_split);
		logic [COORD_W-1:0] c [NUM_AXES];
		logic [IDX_W-1:0] lin;
		for (int k = 0; k < NUM_AXES; k++) begin
			case ($urandom_range(0, 3))
				0: c[k] = COORD_W'($urandom_range(0, 2 * eff_range(cfg_rng[k]))
					- eff_range(cfg_rng[k]));
				default: c[k] = COORD_W'($urandom);
			endcase
		end
		lin = ($urandom_range(0, 1)) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 1 << 20));
		send_word(($urandom_range(0, 99) < pct_split) ? OP_SPLIT : OP_WRAP,
			c[0], c[1], c[2], lin);
	endtask

	task automatic test_reset_grid;
		send_word(OP_WRAP, 16'h8000, 16'h7fff, 16'h0001, '0);
		send_word(OP_SPLIT, '0, '0, '0, '1);
	endtask

	task automatic test_extremes;
		set_grid(2'd3, 11'd1024, 11'd1024, 11'd1024);
		send_word(OP_WRAP, 16'h8000, 16'h7fff, 16'hffff, '0);
		send_word(OP_WRAP, 16'h03ff, 16'h0400, 16'hfc00, '0);
		send_word(OP_SPLIT, 16'hffff, 16'hffff, 16'hffff, '1);
		send_word(OP_SPLIT, '0, '0, '0, '0);
		set_grid(2'd3, 11'd1000, 11'd7, 11'd3);
		send_word(OP_SPLIT, '0, '0, '0, '1);
		send_word(OP_WRAP, 16'hfffd, 16'hfff9, 16'h8000, '1);
		set_grid(2'd0, 11'd0, 11'd2047, 11'd1025);
		send_word(OP_WRAP, 16'hffff, 16'h1234, 16'h4321, '0);
		send_word(OP_SPLIT, '0, '0, '0, 30'h2aaaaaaa);
		set_grid(2'd1, 11'd2047, 11'd5, 11'd5);
		send_word(OP_WRAP, 16'h8001, 16'h0003, 16'h0004, '0);
		send_word(OP_SPLIT, '0, '0, '0, 30'h15555555);
		set_grid(2'd2, 11'd13, 11'd1024, 11'd0);
		send_word(OP_WRAP, 16'hfff3, 16'h8000, 16'h7fff, '0);
		send_word(OP_SPLIT, '0, '0, '0, '1);
	endtask

	task automatic test_random_grids;
		logic [RNG_W-1:0] rr [NUM_AXES];
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		for (int ph = 0; ph < 12; ph++) begin
			for (int k = 0; k < NUM_AXES; k++) begin
				case ($urandom_range(0, 4))
					0: rr[k] = RNG_W'($urandom);
					1: rr[k] = RNG_W'($urandom_range(1, 4));
					default: rr[k] = RNG_W'($urandom_range(1, 1024));
				endcase
			end
			set_grid(2'($urandom), rr[0], rr[1], rr[2]);
			repeat (50) send_random(50);
		end
	endtask

	task automatic test_backpressure;
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		hold_off = 300;
		repeat (150) send_random(50);
	endtask

	task automatic test_full_rate;
		set_grid(2'd3, 11'd17, 11'd9, 11'd1024);
		repeat (100) send_random(50);
	endtask

	always @(posedge clk) begin
		grid_addr_t got;
		grid_addr_t want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got = grid_addr_t'(m_tdata[59:0]);
			if (expected_addrs.size() == 0) begin
				report_mismatch("unexpected word", 32'(got.idx), 32'(0));
			end else begin
				want = expected_addrs.pop_front();
				if (got.idx !== want.idx)
					report_mismatch("index_out", 32'(got.idx), 32'(want.idx));
				if (got.x !== want.x) report_mismatch("wrapped_x", 32'(got.x), 32'(want.x));
				if (got.y !== want.y) report_mismatch("wrapped_y", 32'(got.y), 32'(want.y));
				if (got.z !== want.z) report_mismatch("wrapped_z", 32'(got.z), 32'(want.z));
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			if (recv_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		hold_off = 0;
		cfg_dims = 2'd2;
		for (int k = 0; k < NUM_AXES; k++) cfg_rng[k] = RNG_W'(1);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_grid();
		test_extremes();
		test_random_grids();
		test_backpressure();
		test_full_rate();
		drain();
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
